@@ hw/rtl/prstat_pkg.sv @@
// Package for the per-round receive statistics core.
// Holds the slot record layout, the controller state type and shared constants.
// No dependencies.
package prstat_pkg;

  // Default number of table slots
  localparam int ENTRIES_DEF = 64;

  // Width of the reported slot number (low bits of the slot)
  localparam int SLOT_W = 6;

  // Per-slot statistics record, stored in one memory word
  typedef struct packed {
    logic        [31:0] count;
    logic        [47:0] bytes;
    logic signed [63:0] delay;
    logic        [47:0] min_send;
    logic        [47:0] first_arr;
    logic        [47:0] last_arr;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD,
    ST_NEW
  } state_t;

endpackage

@@ hw/rtl/prstat_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Parameters set word width and depth. No package dependency.
module prstat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/prstat_merge.sv @@
// Record merge datapath: folds one received record into a stored slot record,
// and builds the fresh record for a newly opened slot. Uses prstat_pkg.
module prstat_merge (
  input  prstat_pkg::rec_t old_rec,
  input  logic [47:0]      send_time,
  input  logic [47:0]      arrival_time,
  input  logic [15:0]      len,
  output prstat_pkg::rec_t upd_rec,
  output prstat_pkg::rec_t fresh_rec
);
  import prstat_pkg::*;

  logic signed [48:0] delay_short;
  logic        [63:0] delay_ext;
  logic        [64:0] delay_sum;
  logic        [48:0] bytes_sum;

  // Delay of this record: arrival minus send, signed
  assign delay_short = $signed({1'b0, arrival_time}) - $signed({1'b0, send_time});
  assign delay_ext   = {{15{delay_short[48]}}, delay_short};

  // Wide sums with one guard bit each
  assign delay_sum = {old_rec.delay[63], old_rec.delay} + {delay_ext[63], delay_ext};
  assign bytes_sum = {1'b0, old_rec.bytes} + {33'b0, len};

  // Update an existing slot, saturating the accumulators
  always_comb begin
    upd_rec.count = (&old_rec.count) ? old_rec.count : old_rec.count + 32'd1;
    upd_rec.bytes = bytes_sum[48] ? {48{1'b1}} : bytes_sum[47:0];
    if (delay_sum[64] != delay_sum[63]) begin
      upd_rec.delay = delay_sum[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end else begin
      upd_rec.delay = delay_sum[63:0];
    end
    upd_rec.min_send  = (old_rec.min_send > send_time) ? send_time : old_rec.min_send;
    upd_rec.first_arr = old_rec.first_arr;
    upd_rec.last_arr  = arrival_time;
  end

  // Open a slot with this record alone
  always_comb begin
    fresh_rec.count     = 32'd1;
    fresh_rec.bytes     = {32'b0, len};
    fresh_rec.delay     = delay_ext;
    fresh_rec.min_send  = send_time;
    fresh_rec.first_arr = arrival_time;
    fresh_rec.last_arr  = arrival_time;
  end

endmodule

@@ hw/rtl/per_round_receive_statistics_core.sv @@
// Per-round receive statistics: top level with controller, key and record memories.
// Uses prstat_pkg, prstat_ram and prstat_merge.
//
// Pulse start while busy is low to hand in one record. The round is searched by
// scanning the key memory one slot per cycle over the slots opened so far, then
// the slot record is read, merged and written back. A record that hits slot k
// keeps busy high while slots 0 to k are scanned and the update is written; a
// record for a new round keeps it high while the N open slots are scanned and the
// new slot is opened (a full table gives a drop). The result is shown for exactly
// one cycle, marked by done, in the first cycle in which busy is low; the receiver
// cannot stall it, so it must take every transfer as it comes.
// Slots fill in order from slot 0 and a fill count marks the open ones, so no
// clearing pass is needed after reset.
module per_round_receive_statistics_core #(
  parameter int ENTRIES = prstat_pkg::ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [31:0]                   round_number,
  input  logic [47:0]                   send_time_us,
  input  logic [47:0]                   arrival_time_us,
  input  logic [15:0]                   byte_count,
  output logic                          busy,
  output logic                          done,
  output logic                          was_new,
  output logic                          dropped_full,
  output logic [prstat_pkg::SLOT_W-1:0] slot_index,
  output logic [31:0]                   receive_count,
  output logic [47:0]                   byte_total,
  output logic signed [63:0]            delay_total,
  output logic [47:0]                   earliest_send,
  output logic [47:0]                   first_arrival,
  output logic [47:0]                   last_arrival
);
  import prstat_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  state_t state, state_next;

  logic [IDX_W-1:0] idx;
  logic [CNT_W-1:0] used;
  logic [CNT_W-1:0] idx_inc;
  logic             table_full;
  logic             key_match;

  // Latched record
  logic [31:0] rnd;
  logic [47:0] snd;
  logic [47:0] arr;
  logic [15:0] len;

  // Memory ports
  logic [IDX_W-1:0] key_raddr;
  logic [31:0]      key_rdata;
  logic             key_we;
  logic             rec_we;
  logic [IDX_W-1:0] wr_addr;
  rec_t             rec_wdata;
  rec_t             rec_rdata;
  rec_t             upd_rec;
  rec_t             fresh_rec;

  // Slot number reporting
  logic [IDX_W-1:0]        rep_idx;
  logic [IDX_W+SLOT_W-1:0] rep_ext;

  assign idx_inc    = CNT_W'(idx) + CNT_W'(1);
  assign table_full = (used == CNT_W'(ENTRIES));
  assign key_match  = (key_rdata == rnd);
  assign busy       = (state != ST_IDLE);
  assign wr_addr    = used[IDX_W-1:0];

  // Key memory: round numbers of open slots
  prstat_ram #(
    .WIDTH (32),
    .DEPTH (ENTRIES)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (wr_addr),
    .wdata (rnd),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  // Record memory: statistics of open slots
  prstat_ram #(
    .WIDTH (REC_W),
    .DEPTH (ENTRIES)
  ) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr ((state == ST_UPD) ? idx : wr_addr),
    .wdata (rec_wdata),
    .raddr (idx),
    .rdata (rec_rdata)
  );

  prstat_merge u_merge (
    .old_rec      (rec_rdata),
    .send_time    (snd),
    .arrival_time (arr),
    .len          (len),
    .upd_rec      (upd_rec),
    .fresh_rec    (fresh_rec)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (used == '0) ? ST_NEW : ST_CMP;
        end
      end
      ST_CMP: begin
        if (key_match) begin
          state_next = ST_UPD;
        end else if (idx_inc == used) begin
          state_next = ST_NEW;
        end
      end
      ST_UPD:  state_next = ST_IDLE;
      ST_NEW:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory controls
  always_comb begin
    key_raddr = '0;
    key_we    = 1'b0;
    rec_we    = 1'b0;
    rec_wdata = fresh_rec;
    case (state)
      ST_CMP: begin
        key_raddr = idx_inc[IDX_W-1:0];
      end
      ST_UPD: begin
        rec_we    = 1'b1;
        rec_wdata = upd_rec;
      end
      ST_NEW: begin
        key_we = !table_full;
        rec_we = !table_full;
      end
      default: begin
        key_raddr = '0;
      end
    endcase
  end

  // Report the low bits of the slot number
  assign rep_idx    = (state == ST_UPD) ? idx : wr_addr;
  assign rep_ext    = {{SLOT_W{1'b0}}, rep_idx};

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      used  <= '0;
      idx   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_UPD) || (state == ST_NEW);
      if (state == ST_IDLE && start) begin
        idx <= '0;
      end else if (state == ST_CMP && !key_match) begin
        idx <= idx_inc[IDX_W-1:0];
      end
      if (state == ST_NEW && !table_full) begin
        used <= used + CNT_W'(1);
      end
    end
  end

  // Capture the record on acceptance
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      rnd <= round_number;
      snd <= send_time_us;
      arr <= arrival_time_us;
      len <= byte_count;
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (state == ST_UPD) begin
      was_new       <= 1'b0;
      dropped_full  <= 1'b0;
      slot_index    <= rep_ext[SLOT_W-1:0];
      receive_count <= upd_rec.count;
      byte_total    <= upd_rec.bytes;
      delay_total   <= upd_rec.delay;
      earliest_send <= upd_rec.min_send;
      first_arrival <= upd_rec.first_arr;
      last_arrival  <= upd_rec.last_arr;
    end else if (state == ST_NEW) begin
      if (table_full) begin
        was_new       <= 1'b0;
        dropped_full  <= 1'b1;
        slot_index    <= '0;
        receive_count <= '0;
        byte_total    <= '0;
        delay_total   <= '0;
        earliest_send <= '0;
        first_arrival <= '0;
        last_arrival  <= '0;
      end else begin
        was_new       <= 1'b1;
        dropped_full  <= 1'b0;
        slot_index    <= rep_ext[SLOT_W-1:0];
        receive_count <= fresh_rec.count;
        byte_total    <= fresh_rec.bytes;
        delay_total   <= fresh_rec.delay;
        earliest_send <= fresh_rec.min_send;
        first_arrival <= fresh_rec.first_arr;
        last_arrival  <= fresh_rec.last_arr;
      end
    end
  end

endmodule

@@ bench/per_round_receive_statistics_core_test.sv @@
`timescale 1ns / 100ps
// Self-checking bench for per_round_receive_statistics_core: a scoreboard class predicts
// each slot update and compares every done strobe against it. Depends on prstat_pkg.
module per_round_receive_statistics_core_test;

  import prstat_pkg::*;

  localparam int TABLE_SLOTS = ENTRIES_DEF;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int POOL_SIZE = 72;
  localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

  // One result as it appears on the ports
  typedef struct packed {
    logic              was_new;
    logic              dropped_full;
    logic [SLOT_W-1:0] slot;
    rec_t              stats;
  } round_result_t;

  // Table predictor plus the queue of pending results
  class round_stats_scoreboard;
    logic          slot_open [TABLE_SLOTS];
    logic [31:0]   slot_key  [TABLE_SLOTS];
    rec_t          slot_rec  [TABLE_SLOTS];
    int            slots_taken;
    round_result_t expected_q[$];
    int            errors;

    function new();
      foreach (slot_open[i]) slot_open[i] = 1'b0;
      slots_taken = 0;
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic signed [63:0] add_clamped(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63])
        s = a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
      return s;
    endfunction

    // Predict the entry after one accepted record
    function void note_record(logic [31:0] rnd, logic [47:0] snd, logic [47:0] arr,
                              logic [15:0] len);
      round_result_t res;
      int hit;
      logic signed [63:0] delta;
      logic [48:0] bsum;
      res = '0;
      hit = -1;
      delta = $signed({16'd0, arr}) - $signed({16'd0, snd});
      for (int i = 0; i < slots_taken && hit < 0; i++)
        if (slot_open[i] && slot_key[i] == rnd) hit = i;
      if (hit >= 0) begin
        if (slot_rec[hit].count != 32'hFFFF_FFFF) slot_rec[hit].count++;
        bsum = {1'b0, slot_rec[hit].bytes} + len;
        slot_rec[hit].bytes = bsum[48] ? TIME_MAX : bsum[47:0];
        slot_rec[hit].delay = add_clamped(slot_rec[hit].delay, delta);
        slot_rec[hit].last_arr = arr;
        if (slot_rec[hit].min_send > snd) slot_rec[hit].min_send = snd;
      end else if (slots_taken < TABLE_SLOTS) begin
        hit = slots_taken;
        slot_open[hit] = 1'b1;
        slot_key[hit] = rnd;
        slot_rec[hit].count = 32'd1;
        slot_rec[hit].bytes = {32'd0, len};
        slot_rec[hit].delay = delta;
        slot_rec[hit].min_send = snd;
        slot_rec[hit].first_arr = arr;
        slot_rec[hit].last_arr = arr;
        slots_taken++;
        res.was_new = 1'b1;
      end else begin
        // Table full: drop, all data fields zero
        res.dropped_full = 1'b1;
        expected_q = {expected_q, res};
        return;
      end
      res.slot = hit[SLOT_W-1:0];
      res.stats = slot_rec[hit];
      expected_q = {expected_q, res};
    endfunction

    function void flag(string msg);
      errors++;
      $display("%0t ERROR %s", $time, msg);
    endfunction

    function void field_check(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) flag($sformatf("%s expected %h actual %h", name, e, a));
    endfunction

    // Compare one strobed result against the oldest prediction
    function void check_result(round_result_t got);
      round_result_t e;
      if (expected_q.size() == 0) begin
        flag("result with no pending transfer");
        return;
      end
      e = expected_q[0];
      expected_q.delete(0);
      field_check("was_new", e.was_new, got.was_new);
      field_check("dropped_full", e.dropped_full, got.dropped_full);
      field_check("slot_index", e.slot, got.slot);
      field_check("receive_count", e.stats.count, got.stats.count);
      field_check("byte_total", e.stats.bytes, got.stats.bytes);
      field_check("delay_total", e.stats.delay, got.stats.delay);
      field_check("earliest_send", e.stats.min_send, got.stats.min_send);
      field_check("first_arrival", e.stats.first_arr, got.stats.first_arr);
      field_check("last_arrival", e.stats.last_arr, got.stats.last_arr);
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                start;
  logic [31:0]         round_number;
  logic [47:0]         send_time_us;
  logic [47:0]         arrival_time_us;
  logic [15:0]         byte_count;
  logic                busy;
  logic                done;
  logic                was_new;
  logic                dropped_full;
  logic [SLOT_W-1:0]   slot_index;
  logic [31:0]         receive_count;
  logic [47:0]         byte_total;
  logic signed [63:0]  delay_total;
  logic [47:0]         earliest_send;
  logic [47:0]         first_arrival;
  logic [47:0]         last_arrival;

  round_stats_scoreboard stats_sb = new();
  logic [31:0] round_pool [POOL_SIZE];
  int          cycle_count;
  bit          sender_idles;

  per_round_receive_statistics_core DUT (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .round_number    (round_number),
    .send_time_us    (send_time_us),
    .arrival_time_us (arrival_time_us),
    .byte_count      (byte_count),
    .busy            (busy),
    .done            (done),
    .was_new         (was_new),
    .dropped_full    (dropped_full),
    .slot_index      (slot_index),
    .receive_count   (receive_count),
    .byte_total      (byte_total),
    .delay_total     (delay_total),
    .earliest_send   (earliest_send),
    .first_arrival   (first_arrival),
    .last_arrival    (last_arrival)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Check strobed results, then note accepted transfers
  always @(posedge clk) begin
    round_result_t got;
    if (!rst) begin
      if (done) begin
        got.was_new = was_new;
        got.dropped_full = dropped_full;
        got.slot = slot_index;
        got.stats.count = receive_count;
        got.stats.bytes = byte_total;
        got.stats.delay = delay_total;
        got.stats.min_send = earliest_send;
        got.stats.first_arr = first_arrival;
        got.stats.last_arr = last_arrival;
        stats_sb.check_result(got);
      end
      if (start && !busy)
        stats_sb.note_record(round_number, send_time_us, arrival_time_us, byte_count);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d results pending", $time, stats_sb.pending());
      $display("per_round_receive_statistics_core_test: FAIL");
      $finish;
    end
  end

  // Hand in one record; called and returns at a falling edge
  task automatic send_record(input logic [31:0] r, input logic [47:0] s,
                             input logic [47:0] a, input logic [15:0] n);
    while (busy) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    round_number <= r;
    send_time_us <= s;
    arrival_time_us <= a;
    byte_count <= n;
    @(negedge clk);
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      start <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic maybe_idle();
    if (sender_idles && $urandom_range(99) < 19) idle_cycles($urandom_range(1, 6));
  endtask

  // Hold off the sender until every result is back
  task automatic drain_results();
    while (stats_sb.pending() != 0) begin
      start <= 1'b0;
      @(negedge clk);
    end
  endtask

  function automatic logic [47:0] pick_time();
    case ($urandom_range(9))
      0: return 48'd0;
      1: return TIME_MAX;
      default: return 48'({$urandom(), $urandom()});
    endcase
  endfunction

  function automatic logic [31:0] pick_round();
    int p;
    p = $urandom_range(99);
    if (p < 12) return $urandom();
    if (p < 20) return round_pool[$urandom_range(POOL_SIZE - 1)] ^ (32'd1 << $urandom_range(31));
    return round_pool[$urandom_range(POOL_SIZE - 1)];
  endfunction

  initial begin
    logic [31:0] r;
    logic [47:0] s;
    logic [47:0] a;
    logic [15:0] n;
    rst = 1'b1;
    start = 1'b0;
    round_number = '0;
    send_time_us = '0;
    arrival_time_us = '0;
    byte_count = '0;
    cycle_count = 0;
    sender_idles = 1'b1;
    round_pool[0] = 32'h0000_0000;
    round_pool[1] = 32'hFFFF_FFFF;
    round_pool[2] = 32'h8000_0000;
    round_pool[3] = 32'h5555_5555;
    round_pool[4] = 32'hAAAA_AAAA;
    round_pool[5] = 32'h0000_0001;
    round_pool[6] = 32'h0000_0002;
    for (int i = 7; i < POOL_SIZE; i++) round_pool[i] = $urandom();

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed: field extremes, hits, misses, earliest-send updates, negative delay
    send_record(32'h0000_0000, 48'd0, 48'd0, 16'h0000);
    send_record(32'hFFFF_FFFF, TIME_MAX, 48'd0, 16'hFFFF);
    send_record(32'h0000_0000, 48'd5, TIME_MAX, 16'hFFFF);
    send_record(32'hFFFF_FFFF, 48'd0, TIME_MAX, 16'h0001);
    send_record(32'h8000_0000, 48'd1000, 48'd500, 16'h0001);
    send_record(32'h8000_0000, 48'd999, 48'd2000, 16'h8000);
    send_record(32'h8000_0000, 48'd1001, 48'd2001, 16'h7FFF);
    send_record(32'h5555_5555, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 16'h5555);
    send_record(32'hAAAA_AAAA, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 16'hAAAA);
    idle_cycles(3);
    send_record(32'h0000_0001, 48'd10, 48'd10, 16'd100);
    send_record(32'h0000_0002, 48'd20, 48'd19, 16'd200);
    send_record(32'h5555_5555, 48'h5555_5555_5554, 48'hAAAA_AAAA_AAAB, 16'hAAAA);
    send_record(32'hAAAA_AAAA, 48'hAAAA_AAAA_AAAB, 48'h5555_5555_5554, 16'h5555);
    send_record(32'h0000_0002, 48'd0, 48'd0, 16'd0);
    send_record(32'h0000_0001, TIME_MAX, TIME_MAX, 16'hFFFF);
    drain_results();

    // Pile large positive delays onto slot 0, then step back down
    for (int k = 0; k < 8; k++) begin
      maybe_idle();
      send_record(32'h0000_0000, 48'd0, TIME_MAX, 16'($urandom()));
    end
    send_record(32'h0000_0000, TIME_MAX, 48'd0, 16'd1);
    send_record(32'h0000_0000, 48'd7, 48'd3, 16'd1);

    // Pile large negative delays onto slot 1, then step back up
    for (int k = 0; k < 8; k++) begin
      maybe_idle();
      send_record(32'hFFFF_FFFF, TIME_MAX, 48'd0, 16'($urandom()));
    end
    send_record(32'hFFFF_FFFF, 48'd0, TIME_MAX, 16'd1);
    drain_results();

    // Random records over a pool of rounds; the table fills and later rounds drop
    for (int k = 0; k < 560; k++) begin
      sender_idles = !(k >= 200 && k < 350);
      if (k == 300 || k == 450) drain_results();
      maybe_idle();
      r = pick_round();
      s = pick_time();
      if ($urandom_range(9) < 6) a = s + 48'($urandom_range(0, 100000));
      else a = pick_time();
      case ($urandom_range(7))
        0: n = 16'h0000;
        1: n = 16'hFFFF;
        default: n = 16'($urandom());
      endcase
      send_record(r, s, a, n);
    end

    drain_results();
    idle_cycles(80);
    if (stats_sb.pending() != 0)
      $display("%0t ERROR %0d expected results never arrived", $time, stats_sb.pending());
    if (stats_sb.errors == 0 && stats_sb.pending() == 0) begin
      $display("per_round_receive_statistics_core_test: PASS");
    end else begin
      $display("per_round_receive_statistics_core_test: FAIL");
    end
    $finish;
  end

endmodule
